// ===== design/ctss_pkg.sv =====
// shared types, codes and constants for the capture tachometer speed stepper
`timescale 1ns / 1ps

package ctss_pkg;

  // field widths
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STAMP_W     = 16;
  localparam int unsigned RPM_W       = 8;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned NUM_W       = 32;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned OVF_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned DIV_CNT_W   = 5;

  // reset values
  localparam logic [NUM_W-1:0]  RPM_NUM_RESET      = 32'd1863354;
  localparam logic [DUTY_W-1:0] RESTART_DUTY_RESET = 8'd50;
  localparam logic [DUTY_W-1:0] DUTY_RESET         = 8'd10;

  // divider runs one quotient bit per step
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'd31;

  // limits of the 8-bit speed and duty
  localparam logic [RPM_W-1:0]  RPM_MAX  = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd0;

  // event kinds carried on tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_OVERFLOW = 2'd0,
    FUNC_CAPTURE  = 2'd1,
    FUNC_STOP     = 2'd2,
    FUNC_CONTROL  = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_NUMERATOR = 1'b0,
    CFG_RESTART_DUTY  = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic apply_event;
    logic div_start;
    logic div_step;
    logic div_finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== design/ctss_ctrl.sv =====
// controller state machine: handshakes and sequencing of the divide
`timescale 1ns / 1ps

module ctss_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ctss_pkg::func_e       in_func_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctss_pkg::dp_cmd_t     cmd_o,
  input  ctss_pkg::dp_status_t  status_i
);

  ctss_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic                  accept;

  // output slot is free when empty or being taken this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ctss_pkg::ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctss_pkg::ST_IDLE: begin
        if (accept && (in_func_i == ctss_pkg::FUNC_CONTROL)) begin
          state_d = ctss_pkg::ST_DIVIDE;
        end
      end
      ctss_pkg::ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ctss_pkg::ST_FINISH;
        end
      end
      ctss_pkg::ST_FINISH: begin
        state_d = ctss_pkg::ST_IDLE;
      end
      default: begin
        state_d = ctss_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: datapath commands and output valid
  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ctss_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func_i == ctss_pkg::FUNC_CONTROL) begin
            cmd_o.div_start = 1'b1;
          end else begin
            cmd_o.apply_event = 1'b1;
            out_valid_d       = 1'b1;
          end
        end
      end
      ctss_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ctss_pkg::ST_FINISH: begin
        cmd_o.div_finish = 1'b1;
        out_valid_d      = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // state and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctss_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/ctss_dp.sv =====
// datapath: tachometer state, configuration, bit-serial divider, duty stepping
`timescale 1ns / 1ps

module ctss_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  ctss_pkg::func_e                     func_i,
  input  logic [ctss_pkg::STAMP_W-1:0]        stamp_i,
  input  logic [ctss_pkg::RPM_W-1:0]          target_i,
  input  ctss_pkg::dp_cmd_t                   cmd_i,
  output ctss_pkg::dp_status_t                status_o,
  output logic [ctss_pkg::DUTY_W-1:0]         duty_o,
  output logic [ctss_pkg::RPM_W-1:0]          real_rpm_o,
  output logic                                drive_enabled_o
);

  localparam int unsigned NW = ctss_pkg::NUM_W;
  localparam int unsigned PW = ctss_pkg::PERIOD_W;

  // configuration registers
  logic [NW-1:0]                   rpm_num_q;
  logic [ctss_pkg::DUTY_W-1:0]     restart_duty_q;

  // tachometer and controller state
  logic [ctss_pkg::OVF_W-1:0]      ovf_cnt_q, ovf_cnt_d;
  logic [ctss_pkg::STAMP_W-1:0]    last_stamp_q, last_stamp_d;
  logic [PW-1:0]                   period_q, period_d;
  logic [ctss_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic [ctss_pkg::RPM_W-1:0]      speed_q, speed_d;
  logic                            drive_on_q, drive_on_d;

  // divider registers
  logic [PW-1:0]                   rem_q, rem_d;
  logic [NW-1:0]                   quo_q, quo_d;
  logic [ctss_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [ctss_pkg::RPM_W-1:0]      target_q, target_d;

  logic [PW:0]                     shifted;
  logic [PW:0]                     diff;
  logic                            ge;
  logic [ctss_pkg::RPM_W-1:0]      speed_sat;
  logic [ctss_pkg::DUTY_W-1:0]     duty_step;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_num_q      <= ctss_pkg::RPM_NUM_RESET;
      restart_duty_q <= ctss_pkg::RESTART_DUTY_RESET;
    end else if (cfg_we_i) begin
      unique case (ctss_pkg::cfg_idx_e'(cfg_index_i))
        ctss_pkg::CFG_RPM_NUMERATOR: rpm_num_q      <= cfg_data_i[NW-1:0];
        ctss_pkg::CFG_RESTART_DUTY:  restart_duty_q <= cfg_data_i[ctss_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // one restoring division step
  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, period_q};
  assign ge      = (shifted >= {1'b0, period_q});

  // saturated speed from the finished quotient
  assign speed_sat = (|quo_q[NW-1:ctss_pkg::RPM_W]) ? ctss_pkg::RPM_MAX
                                                    : quo_q[ctss_pkg::RPM_W-1:0];

  // duty one unit off the target: below it when the speed is above, above it when below, held at the ends
  always_comb begin
    if (speed_sat > target_q) begin
      duty_step = (target_q == ctss_pkg::DUTY_MIN) ? ctss_pkg::DUTY_MIN
                                                   : target_q - 1'b1;
    end else if (target_q > speed_sat) begin
      duty_step = (target_q == ctss_pkg::DUTY_MAX) ? ctss_pkg::DUTY_MAX
                                                   : target_q + 1'b1;
    end else begin
      duty_step = target_q;
    end
  end

  // event and divider next values
  always_comb begin
    ovf_cnt_d    = ovf_cnt_q;
    last_stamp_d = last_stamp_q;
    period_d     = period_q;
    duty_d       = duty_q;
    speed_d      = speed_q;
    drive_on_d   = drive_on_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    target_d     = target_q;

    if (cmd_i.apply_event) begin
      case (func_i)
        ctss_pkg::FUNC_OVERFLOW: begin
          ovf_cnt_d = ovf_cnt_q + 1'b1;
        end
        ctss_pkg::FUNC_CAPTURE: begin
          period_d     = {ovf_cnt_q, {ctss_pkg::STAMP_W{1'b0}}}
                         - {{(PW-ctss_pkg::STAMP_W){1'b0}}, last_stamp_q}
                         + {{(PW-ctss_pkg::STAMP_W){1'b0}}, stamp_i};
          last_stamp_d = stamp_i;
          ovf_cnt_d    = '0;
        end
        ctss_pkg::FUNC_STOP: begin
          drive_on_d = !drive_on_q;
          period_d   = '0;
          duty_d     = restart_duty_q;
        end
        default: ;
      endcase
    end

    if (cmd_i.div_start) begin
      rem_d    = '0;
      quo_d    = rpm_num_q;
      cnt_d    = '0;
      target_d = target_i;
    end

    if (cmd_i.div_step) begin
      rem_d = ge ? diff[PW-1:0] : shifted[PW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.div_finish) begin
      speed_d = speed_sat;
      duty_d  = duty_step;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_cnt_q    <= '0;
      last_stamp_q <= '0;
      period_q     <= '0;
      duty_q       <= ctss_pkg::DUTY_RESET;
      speed_q      <= '0;
      drive_on_q   <= 1'b1;
    end else begin
      ovf_cnt_q    <= ovf_cnt_d;
      last_stamp_q <= last_stamp_d;
      period_q     <= period_d;
      duty_q       <= duty_d;
      speed_q      <= speed_d;
      drive_on_q   <= drive_on_d;
    end
  end

  // divider working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
      target_q <= '0;
    end else begin
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      cnt_q    <= cnt_d;
      target_q <= target_d;
    end
  end

  assign status_o.div_last = (cnt_q == ctss_pkg::DIV_LAST_STEP);

  assign duty_o          = duty_q;
  assign real_rpm_o      = speed_q;
  assign drive_enabled_o = drive_on_q;

endmodule

// ===== design/capture_tachometer_speed_stepper_top.sv =====
// top level of the capture tachometer speed stepper
//
// channel  | direction | tdata / tuser                              | beat
// s_axis   | in        | tuser: func; tdata: stamp, expected_rpm    | one event
// m_axis   | out       | tdata: duty, real_rpm, drive_enabled       | one result
// cfg      | in        | cfg_index_i, cfg_data_i                    | one register write
//
// overflow, capture and stop events are applied when taken; the result is valid the next cycle
// a control update runs one start step, 32 divider steps of one quotient bit each
// and one step for the duty
// reset (rst_ni low) restores all registers at once, no clearing pass
// a stalled result holds its beat; the next event is taken in the cycle it leaves
`timescale 1ns / 1ps

module capture_tachometer_speed_stepper_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // events
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ctss_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,  // [15:0] capture_stamp, [23:16] expected_rpm
  input  logic [ctss_pkg::FUNC_W-1:0]          s_axis_tuser_i,  // [1:0] func
  // results
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [ctss_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,  // [7:0] duty, [15:8] real_rpm, [16] drive_enabled
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  ctss_pkg::dp_cmd_t               cmd;
  ctss_pkg::dp_status_t            status;
  ctss_pkg::func_e                 func;
  logic [ctss_pkg::DUTY_W-1:0]     duty;
  logic [ctss_pkg::RPM_W-1:0]      real_rpm;
  logic                            drive_enabled;

  assign func        = ctss_pkg::func_e'(s_axis_tuser_i);
  assign cfg_ready_o = 1'b1;

  // controller
  ctss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (func),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath
  ctss_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func),
    .stamp_i         (s_axis_tdata_i[ctss_pkg::STAMP_W-1:0]),
    .target_i        (s_axis_tdata_i[ctss_pkg::STAMP_W +: ctss_pkg::RPM_W]),
    .cmd_i           (cmd),
    .status_o        (status),
    .duty_o          (duty),
    .real_rpm_o      (real_rpm),
    .drive_enabled_o (drive_enabled)
  );

  // result beat packing
  assign m_axis_tdata_o = {
    {(ctss_pkg::OUT_DATA_W - ctss_pkg::DUTY_W - ctss_pkg::RPM_W - 1){1'b0}},
    drive_enabled, real_rpm, duty
  };

endmodule

// ===== design/ctss_chk.sv =====
// port-level checker for the capture tachometer speed stepper, with its bind
`timescale 1ns / 1ps

module ctss_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  input  logic                                 s_tready_i,
  input  logic [ctss_pkg::FUNC_W-1:0]          s_tuser_i,
  input  logic                                 m_tvalid_i,
  input  logic                                 m_tready_i,
  input  logic [ctss_pkg::OUT_DATA_W-1:0]      m_tdata_i
);

  localparam int unsigned EN_BIT = ctss_pkg::DUTY_W + ctss_pkg::RPM_W;

  logic in_beat;
  logic is_ctrl;
  logic is_stop;

  assign in_beat = s_tvalid_i && s_tready_i;
  assign is_ctrl = (s_tuser_i == ctss_pkg::FUNC_CONTROL);
  assign is_stop = (s_tuser_i == ctss_pkg::FUNC_STOP);

  // simple events answer in the next cycle
  a_simple_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !is_ctrl |=> m_tvalid_i)
    else $error("simple event gave no result in the next cycle");

  // a control update blocks new events while dividing
  a_ctrl_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && is_ctrl |=> !s_tready_i && !m_tvalid_i)
    else $error("input taken or result shown during divide");

  // a control update answers after the full divide
  a_ctrl_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && is_ctrl |=> ##33 m_tvalid_i)
    else $error("control update result not on time");

  // stop event flips the drive enable
  a_stop_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && is_stop |=> m_tdata_i[EN_BIT] != $past(m_tdata_i[EN_BIT]))
    else $error("stop event did not toggle drive enable");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result beat changed");

endmodule

bind capture_tachometer_speed_stepper_top ctss_chk u_ctss_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
